/* src/imud_pkg.sv */
// shared types and constants for the imu packet deframer
package imud_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h41;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [7:0] SUM_START   = SYNC_FIRST + SYNC_SECOND;

    localparam int PAYLOAD_FIRST = 3;
    localparam int PAYLOAD_COUNT = 20;
    localparam int WORD_COUNT    = 10;
    localparam int IDX_W         = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        ITEM_START,
        ITEM_DATA,
        ITEM_LAST
    } item_kind_t;

    // one classified byte travelling from the front to the back
    typedef struct packed {
        item_kind_t         kind;
        logic               store;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         data;
    } item_t;

    typedef struct packed {
        logic [WORD_COUNT-1:0][15:0] words;
        logic                        checksum_ok;
    } result_t;

endpackage

/* src/imud_front.sv */
// front end: sync hunt, packet position tracking and byte classification
module imud_front #(
    parameter int PACKET_BYTES = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [7:0]           s_rx_byte,
    output logic                 s_ready,
    input  logic                 fifo_full,
    output logic                 push,
    output imud_pkg::item_t      push_item
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(imud_pkg::PAYLOAD_FIRST);
    localparam logic [POS_W-1:0] END_POS   =
        POS_W'(imud_pkg::PAYLOAD_FIRST + imud_pkg::PAYLOAD_COUNT);
    localparam logic [POS_W-1:0] DATA_POS  = POS_W'(2);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC1,
        PH_COLLECT
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] rel_pos;
    logic             accept;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign rel_pos = pos_reg - FIRST_POS;

    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        push            = 1'b0;
        push_item.kind  = imud_pkg::ITEM_DATA;
        push_item.store = (pos_reg >= FIRST_POS) && (pos_reg < END_POS);
        push_item.idx   = rel_pos[imud_pkg::IDX_W-1:0];
        push_item.data  = s_rx_byte;
        if (accept) begin
            unique case (phase_reg)
                PH_SYNC1: begin
                    if (s_rx_byte == imud_pkg::SYNC_SECOND) begin
                        phase_next     = PH_COLLECT;
                        pos_next       = DATA_POS;
                        push           = 1'b1;
                        push_item.kind = imud_pkg::ITEM_START;
                    end else if (s_rx_byte != imud_pkg::SYNC_FIRST) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_COLLECT: begin
                    push = 1'b1;
                    if (pos_reg == LAST_POS) begin
                        push_item.kind = imud_pkg::ITEM_LAST;
                        phase_next     = PH_HUNT;
                        pos_next       = '0;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default: begin
                    phase_next = (s_rx_byte == imud_pkg::SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

/* src/imud_fifo.sv */
// short queue of classified bytes between front and back
module imud_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  imud_pkg::item_t      push_item,
    output logic                 full,
    input  logic                 pop,
    output imud_pkg::item_t      pop_item,
    output logic                 empty
);

    imud_pkg::item_t                     mem [imud_pkg::FIFO_DEPTH];
    logic [imud_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [imud_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [imud_pkg::FIFO_CNT_W-1:0]     count_reg, count_next;

    assign full     = count_reg == imud_pkg::FIFO_CNT_W'(imud_pkg::FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + imud_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + imud_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + imud_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - imud_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/imud_back.sv */
// back end: checksum accumulation, payload capture and result register
module imud_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 empty,
    input  imud_pkg::item_t      item,
    output logic                 pop,
    input  logic                 m_ready,
    output logic                 m_valid,
    output imud_pkg::result_t    result
);

    logic [7:0]          field_reg [imud_pkg::PAYLOAD_COUNT];
    logic [7:0]          sum_reg, sum_next;
    logic                valid_reg, valid_next;
    imud_pkg::result_t   result_reg, result_next;
    logic                load;

    // the last byte may only leave the queue when the output slot frees up
    assign pop     = !empty && (item.kind != imud_pkg::ITEM_LAST || !valid_reg || m_ready);
    assign load    = pop && item.kind == imud_pkg::ITEM_LAST;
    assign m_valid = valid_reg;
    assign result  = result_reg;

    always_comb begin
        sum_next   = sum_reg;
        valid_next = valid_reg && !m_ready;
        for (int k = 0; k < imud_pkg::WORD_COUNT; k++) begin
            result_next.words[k] = {field_reg[2*k], field_reg[2*k+1]};
        end
        result_next.checksum_ok = sum_reg == item.data;
        if (pop) begin
            unique case (item.kind)
                imud_pkg::ITEM_START: sum_next = imud_pkg::SUM_START;
                imud_pkg::ITEM_DATA:  sum_next = sum_reg + item.data;
                imud_pkg::ITEM_LAST: begin
                    sum_next   = '0;
                    valid_next = 1'b1;
                end
                default: sum_next = sum_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && item.kind == imud_pkg::ITEM_DATA && item.store) begin
            field_reg[item.idx] <= item.data;
        end
        if (load) begin
            result_reg <= result_next;
        end
    end

endmodule

/* src/imu_packet_deframer_top.sv */
// top level of the imu packet deframer
// Takes one byte per cycle with no bubbles while the result side keeps up. A front end hunts for
// the 0x41 0x5A sync pair and tags each packet byte; a four-entry queue carries the tagged bytes
// to a back end that keeps the mod-256 sum and the twenty payload bytes. The result transaction
// shows on the m_ port once the last byte has passed the queue into the back end, and it holds
// in an output register so the next packet keeps flowing in meanwhile. Input stalls only when the
// queue fills, which happens only if a result is left waiting for more than a whole packet's
// worth of bytes. There is no clearing pass after reset; payload storage needs none.
module imu_packet_deframer_top #(
    parameter int PACKET_BYTES = 50
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_accel_x,
    output logic signed [15:0] m_accel_y,
    output logic signed [15:0] m_accel_z,
    output logic signed [15:0] m_gyro_x,
    output logic signed [15:0] m_gyro_y,
    output logic signed [15:0] m_gyro_z,
    output logic signed [15:0] m_mag_x,
    output logic signed [15:0] m_mag_y,
    output logic signed [15:0] m_mag_z,
    output logic signed [15:0] m_temp_raw,
    output logic               m_checksum_ok
);

    logic               fifo_full;
    logic               fifo_empty;
    logic               push;
    logic               pop;
    imud_pkg::item_t    push_item;
    imud_pkg::item_t    pop_item;
    imud_pkg::result_t  result;

    imud_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_rx_byte (s_rx_byte),
        .s_ready   (s_ready),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    imud_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    imud_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (fifo_empty),
        .item    (pop_item),
        .pop     (pop),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .result  (result)
    );

    assign m_accel_x     = result.words[0];
    assign m_accel_y     = result.words[1];
    assign m_accel_z     = result.words[2];
    assign m_gyro_x      = result.words[3];
    assign m_gyro_y      = result.words[4];
    assign m_gyro_z      = result.words[5];
    assign m_mag_x       = result.words[6];
    assign m_mag_y       = result.words[7];
    assign m_mag_z       = result.words[8];
    assign m_temp_raw    = result.words[9];
    assign m_checksum_ok = result.checksum_ok;

endmodule

/* src/imud_checker.sv */
// port-level checks for the imu packet deframer, bound to the top level
module imud_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_accel_x,
    input logic signed [15:0] m_accel_y,
    input logic signed [15:0] m_accel_z,
    input logic signed [15:0] m_gyro_x,
    input logic signed [15:0] m_gyro_y,
    input logic signed [15:0] m_gyro_z,
    input logic signed [15:0] m_mag_x,
    input logic signed [15:0] m_mag_y,
    input logic signed [15:0] m_mag_z,
    input logic signed [15:0] m_temp_raw,
    input logic               m_checksum_ok
);

    // nothing left pending in the output slot after reset
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue comes out of reset empty, so input is open
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accel_x) && $stable(m_accel_y)
            && $stable(m_accel_z) && $stable(m_gyro_x) && $stable(m_gyro_y)
            && $stable(m_gyro_z) && $stable(m_mag_x) && $stable(m_mag_y)
            && $stable(m_mag_z) && $stable(m_temp_raw) && $stable(m_checksum_ok))
        else $error("stalled result changed");

endmodule

bind imu_packet_deframer_top imud_checker u_imud_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_accel_x     (m_accel_x),
    .m_accel_y     (m_accel_y),
    .m_accel_z     (m_accel_z),
    .m_gyro_x      (m_gyro_x),
    .m_gyro_y      (m_gyro_y),
    .m_gyro_z      (m_gyro_z),
    .m_mag_x       (m_mag_x),
    .m_mag_y       (m_mag_y),
    .m_mag_z       (m_mag_z),
    .m_temp_raw    (m_temp_raw),
    .m_checksum_ok (m_checksum_ok)
);

/* sim/imu_packet_deframer_top_tb.sv */
// self-checking testbench for the imu packet deframer top level
`timescale 1ns / 1ps

module imu_packet_deframer_top_tb;

    localparam int PACKET_BYTES  = 50;
    localparam int RANDOM_BYTES  = 1100;
    localparam int MIN_FRAMES    = 33;
    localparam int TAIL_FRAMES   = 3;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LIMIT_CYCLES  = 400000;

    typedef enum logic [1:0] {
        HUNT,
        SYNC_SEEN,
        COLLECT
    } hunt_state_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_FRAME
    } row_kind_t;

    // one directed step: a lone byte, or a whole frame of constant or random body bytes
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  value;
        logic        bad_sum;
        logic        typed;
        logic [15:0] exp_word;
        logic        exp_ok;
    } row_t;

    localparam int DIRECTED_ROWS = 15;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_BYTE,  8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE,  8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE,  8'h5A, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE,  8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE,  8'h33, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE,  8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_FRAME, 8'h00, 1'b0, 1'b1, 16'h0000, 1'b1},
        '{ROW_FRAME, 8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b1},
        '{ROW_FRAME, 8'h80, 1'b1, 1'b1, 16'h8080, 1'b0},
        '{ROW_FRAME, 8'h7F, 1'b0, 1'b1, 16'h7F7F, 1'b1},
        '{ROW_FRAME, 8'h41, 1'b0, 1'b1, 16'h4141, 1'b1},
        '{ROW_FRAME, 8'h5A, 1'b1, 1'b1, 16'h5A5A, 1'b0},
        '{ROW_BYTE,  8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE,  8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{ROW_FRAME, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_accel_x;
    logic signed [15:0] m_accel_y;
    logic signed [15:0] m_accel_z;
    logic signed [15:0] m_gyro_x;
    logic signed [15:0] m_gyro_y;
    logic signed [15:0] m_gyro_z;
    logic signed [15:0] m_mag_x;
    logic signed [15:0] m_mag_y;
    logic signed [15:0] m_mag_z;
    logic signed [15:0] m_temp_raw;
    logic               m_checksum_ok;

    // predictor state
    hunt_state_t hunt_state;
    logic [7:0]  frame_pos;
    logic [7:0]  frame_sum;
    logic [7:0]  payload [imud_pkg::PAYLOAD_COUNT];

    imud_pkg::result_t pending_frames [$];
    bit                quiet;
    int                errors;
    int                bytes_sent;
    int                frames_predicted;
    int                frames_checked;
    int                bad_sums_checked;
    int                cycles;
    imud_pkg::result_t got_frame;
    imud_pkg::result_t want_frame;

    imu_packet_deframer_top #(
        .PACKET_BYTES(PACKET_BYTES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accel_x    (m_accel_x),
        .m_accel_y    (m_accel_y),
        .m_accel_z    (m_accel_z),
        .m_gyro_x     (m_gyro_x),
        .m_gyro_y     (m_gyro_y),
        .m_gyro_z     (m_gyro_z),
        .m_mag_x      (m_mag_x),
        .m_mag_y      (m_mag_y),
        .m_mag_z      (m_mag_z),
        .m_temp_raw   (m_temp_raw),
        .m_checksum_ok(m_checksum_ok)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d frames outstanding", $time, pending_frames.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // advance the deframer by one byte, returns 1 when a frame completes
    function automatic bit deframe_byte(input logic [7:0] b, output imud_pkg::result_t frame);
        bit done;
        done  = 1'b0;
        frame = '0;
        case (hunt_state)
            SYNC_SEEN: begin
                if (b == imud_pkg::SYNC_SECOND) begin
                    hunt_state = COLLECT;
                    frame_pos  = 8'd2;
                    frame_sum  = imud_pkg::SUM_START;
                end else if (b != imud_pkg::SYNC_FIRST) begin
                    hunt_state = HUNT;
                end
            end
            COLLECT: begin
                if (frame_pos >= PACKET_BYTES - 1) begin
                    for (int k = 0; k < imud_pkg::WORD_COUNT; k++) begin
                        frame.words[k] = {payload[2*k], payload[2*k+1]};
                    end
                    frame.checksum_ok = (frame_sum == b);
                    hunt_state = HUNT;
                    frame_pos  = 8'd0;
                    frame_sum  = 8'd0;
                    done       = 1'b1;
                end else begin
                    frame_sum = frame_sum + b;
                    if (frame_pos >= imud_pkg::PAYLOAD_FIRST &&
                        frame_pos < imud_pkg::PAYLOAD_FIRST + imud_pkg::PAYLOAD_COUNT) begin
                        payload[frame_pos - imud_pkg::PAYLOAD_FIRST] = b;
                    end
                    frame_pos = frame_pos + 8'd1;
                end
            end
            default: hunt_state = (b == imud_pkg::SYNC_FIRST) ? SYNC_SEEN : HUNT;
        endcase
        return done;
    endfunction

    function automatic string word_name(input int k);
        case (k)
            0: return "accel_x";
            1: return "accel_y";
            2: return "accel_z";
            3: return "gyro_x";
            4: return "gyro_y";
            5: return "gyro_z";
            6: return "mag_x";
            7: return "mag_y";
            8: return "mag_z";
            default: return "temp_raw";
        endcase
    endfunction

    // returns at the rising edge where the transaction was taken, valid still high
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input imud_pkg::result_t typed_frame);
        imud_pkg::result_t frame;
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (deframe_byte(b, frame)) begin
            frames_predicted++;
            pending_frames.push_back(typed ? typed_frame : frame);
        end
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // body bytes are either the fill value or random, with sync values mixed in now and then
    task automatic send_frame(input logic [7:0] fill, input bit rand_body, input bit bad_sum,
                              input bit typed, input imud_pkg::result_t typed_frame);
        logic [7:0] sum;
        logic [7:0] b;
        send_plain(imud_pkg::SYNC_FIRST);
        send_plain(imud_pkg::SYNC_SECOND);
        sum = imud_pkg::SUM_START;
        for (int i = 2; i < PACKET_BYTES - 1; i++) begin
            if (!rand_body) begin
                b = fill;
            end else begin
                case ($urandom_range(0, 15))
                    0:       b = imud_pkg::SYNC_FIRST;
                    1:       b = imud_pkg::SYNC_SECOND;
                    2:       b = 8'h00;
                    3:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end
            sum = sum + b;
            send_plain(b);
        end
        if (bad_sum) begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        send_byte(sum, typed, typed_frame);
    endtask

    initial begin
        imud_pkg::result_t typed_frame;
        logic [7:0] b;
        int n;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        quiet     = 1'b0;
        errors    = 0;
        cycles    = 0;
        bytes_sent = 0;
        frames_predicted = 0;
        frames_checked = 0;
        bad_sums_checked = 0;
        hunt_state = HUNT;
        frame_pos  = 8'd0;
        frame_sum  = 8'd0;
        for (int i = 0; i < imud_pkg::PAYLOAD_COUNT; i++) payload[i] = 8'h00;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int k = 0; k < imud_pkg::WORD_COUNT; k++) begin
                typed_frame.words[k] = DIRECTED[r].exp_word;
            end
            typed_frame.checksum_ok = DIRECTED[r].exp_ok;
            if (DIRECTED[r].kind == ROW_BYTE) begin
                send_plain(DIRECTED[r].value);
            end else begin
                send_frame(DIRECTED[r].value, !DIRECTED[r].typed, DIRECTED[r].bad_sum,
                           DIRECTED[r].typed, typed_frame);
            end
        end

        for (int iter = 0; bytes_sent < RANDOM_BYTES || frames_predicted < MIN_FRAMES; iter++) begin
            // hold off once until the result side has caught up completely
            if (iter == 12) begin
                drop_valid();
                while (pending_frames.size() != 0) @(posedge aclk);
            end
            case ($urandom_range(0, 9))
                6: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_plain(8'($urandom_range(0, 255)));
                end
                7: begin
                    b = 8'($urandom_range(0, 255));
                    if (b == imud_pkg::SYNC_SECOND) b = b ^ 8'h01;
                    send_plain(imud_pkg::SYNC_FIRST);
                    send_plain(b);
                end
                8: begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_plain(imud_pkg::SYNC_FIRST);
                    send_frame(8'h00, 1'b1, $urandom_range(0, 6) == 0, 1'b0, '0);
                end
                9: begin
                    // a cut-short frame: the garbage after it is swallowed as packet data
                    send_plain(imud_pkg::SYNC_FIRST);
                    send_plain(imud_pkg::SYNC_SECOND);
                    n = $urandom_range(1, 20);
                    repeat (n) send_plain(8'($urandom_range(0, 255)));
                end
                default: send_frame(8'h00, 1'b1, $urandom_range(0, 6) == 0, 1'b0, '0);
            endcase
        end

        // last stretch runs flat out on both sides
        quiet = 1'b1;
        repeat (TAIL_FRAMES) send_frame(8'h00, 1'b1, 1'b0, 1'b0, '0);
        drop_valid();

        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_frames.size() != 0) begin
            $display("%0t: %0d expected frames never arrived", $time, pending_frames.size());
            errors++;
        end

        $display("sent %0d bytes with random gaps and stalls, incl. noise and broken sync pairs",
                 bytes_sent);
        $display("checked %0d frames, %0d of them with a bad checksum",
                 frames_checked, bad_sums_checked);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side stalls in bursts
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet || $urandom_range(0, 9) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_frame.words[0] = m_accel_x;
            got_frame.words[1] = m_accel_y;
            got_frame.words[2] = m_accel_z;
            got_frame.words[3] = m_gyro_x;
            got_frame.words[4] = m_gyro_y;
            got_frame.words[5] = m_gyro_z;
            got_frame.words[6] = m_mag_x;
            got_frame.words[7] = m_mag_y;
            got_frame.words[8] = m_mag_z;
            got_frame.words[9] = m_temp_raw;
            got_frame.checksum_ok = m_checksum_ok;
            if (pending_frames.size() == 0) begin
                $display("%0t: result transaction with no frame expected", $time);
                errors++;
            end else begin
                want_frame = pending_frames.pop_front();
                frames_checked++;
                if (!want_frame.checksum_ok) bad_sums_checked++;
                for (int k = 0; k < imud_pkg::WORD_COUNT; k++) begin
                    if (got_frame.words[k] !== want_frame.words[k]) begin
                        $display("%0t: %s mismatch, expected %0d, got %0d", $time, word_name(k),
                                 $signed(want_frame.words[k]), $signed(got_frame.words[k]));
                        errors++;
                    end
                end
                if (got_frame.checksum_ok !== want_frame.checksum_ok) begin
                    $display("%0t: checksum_ok mismatch, expected %0b, got %0b", $time,
                             want_frame.checksum_ok, got_frame.checksum_ok);
                    errors++;
                end
            end
        end
    end

endmodule
